@@ hw/rtl/diverging_colormap_macros.svh @@
// Assertion macros for the diverging colormap block.
// Define ASSERT_OFF to compile every check away.
`ifndef DIVERGING_COLORMAP_MACROS_SVH
`define DIVERGING_COLORMAP_MACROS_SVH

`ifndef ASSERT_OFF

// Checks that expr holds in the same cycle whenever cond holds.
`define DCMAP_ASSERT_IMPLY(label, clk, rst, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// Checks that expr holds in the cycle after cond holds.
`define DCMAP_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`else

`define DCMAP_ASSERT_IMPLY(label, clk, rst, cond, expr, msg)
`define DCMAP_ASSERT_NEXT(label, clk, rst, cond, expr, msg)

`endif

`endif

@@ hw/rtl/dcmap_pkg.sv @@
`default_nettype none

package dcmap_pkg;

  localparam int VALUE_WIDTH     = 32;
  localparam int COLOR_WIDTH     = 8;
  localparam int FRAC_BITS       = 32;
  localparam int QUOT_WIDTH      = FRAC_BITS + 1;
  localparam int REM_WIDTH       = VALUE_WIDTH + 1;
  localparam int BOUND_WIDTH     = VALUE_WIDTH + 1;
  localparam int DIV_CELLS       = QUOT_WIDTH;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int MODE_WIDTH      = 2;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef logic signed [BOUND_WIDTH-1:0] bound_t;
  typedef logic [COLOR_WIDTH-1:0]        color_t;
  typedef logic [MODE_WIDTH-1:0]         mode_t;
  typedef logic [CFG_INDEX_WIDTH-1:0]    cfg_index_t;

  localparam cfg_index_t REG_RANGE_MIN      = 2'd0;
  localparam cfg_index_t REG_RANGE_MAX      = 2'd1;
  localparam cfg_index_t REG_ZERO_SYMMETRIC = 2'd2;
  localparam cfg_index_t REG_COLOR_MODE     = 2'd3;

  localparam mode_t MODE_PINK   = 2'd0;
  localparam mode_t MODE_WHITE  = 2'd1;
  localparam mode_t MODE_YELLOW = 2'd2;

  localparam value_t RANGE_MIN_RESET = VALUE_WIDTH'(-65536);
  localparam value_t RANGE_MAX_RESET = VALUE_WIDTH'(65536);

  localparam color_t COLOR_FULL = '1;

  // Quotient that stands for a fraction of exactly one.
  localparam logic [QUOT_WIDTH-1:0] QUOT_ONE = QUOT_WIDTH'(1) << FRAC_BITS;

  typedef struct packed {
    logic below;
    logic above;
    logic lower;
  } flags_t;

  // One word as it travels down the divider chain.
  typedef struct packed {
    logic                   valid;
    flags_t                 flags;
    logic [REM_WIDTH-1:0]   rem;
    logic [VALUE_WIDTH-1:0] divisor;
    logic [QUOT_WIDTH-1:0]  quot;
  } cell_t;

  typedef struct packed {
    color_t red;
    color_t green;
    color_t blue;
  } rgb_t;

endpackage

`default_nettype wire

@@ hw/rtl/dcmap_if.sv @@
`default_nettype none

interface dcmap_sample_if;
  import dcmap_pkg::*;

  logic   valid;
  logic   ready;
  value_t sample_value;

  modport source (output valid, output sample_value, input ready);
  modport sink (input valid, input sample_value, output ready);
endinterface

interface dcmap_color_if;
  import dcmap_pkg::*;

  logic   valid;
  logic   ready;
  color_t red;
  color_t green;
  color_t blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/diverging_colormap.sv @@
// Diverging blue-to-red colormap. Each word on the samples channel is a
// signed Q16.16 value; each word on the colors channel is its 8-bit RGB
// colour, running from pure blue at the lower bound through a mid colour
// (pink, white or yellow, chosen by color_mode) to pure red at the upper
// bound, with values outside the bounds clamped to blue or red. Setting
// zero_symmetric mirrors the bound of larger magnitude about zero. The block
// takes one word per clock while its skid word is empty. The divider is a
// row of 33 restoring cells that each settle one quotient bit, behind the
// front's range preparation registers a, b and head and one output register.
// A skid word behind the output register means that samples.ready falls
// in the cycle after the colors side first refuses a word, and then only
// if another word has reached the end of the divider. The user must write
// registers through cfg_we, cfg_index and cfg_data only while no word is
// in flight; the block itself does not enforce this.

`default_nettype none

`include "diverging_colormap_macros.svh"

module diverging_colormap (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  dcmap_pkg::cfg_index_t         cfg_index,
  input  logic [dcmap_pkg::VALUE_WIDTH-1:0] cfg_data,
  dcmap_sample_if.sink                  samples,
  dcmap_color_if.source                 colors
);
  import dcmap_pkg::*;

  value_t                 range_min;
  value_t                 range_max;
  logic                   zero_symmetric;
  mode_t                  color_mode;

  logic [VALUE_WIDTH-1:0] mag_min;
  logic [VALUE_WIDTH-1:0] mag_max;
  logic [VALUE_WIDTH-1:0] mag_sat;
  bound_t                 min_ext;
  bound_t                 max_ext;
  bound_t                 lo_eff;
  bound_t                 hi_eff;

  logic                   adv;
  logic                   skid_full;
  cell_t                  chain [DIV_CELLS+1];

  cell_t                  tail;
  logic                   tail_in_range;
  logic                   out_refused;
  logic                   green_ok;

  localparam logic [VALUE_WIDTH-1:0] POS_LIMIT = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      range_min      <= RANGE_MIN_RESET;
      range_max      <= RANGE_MAX_RESET;
      zero_symmetric <= 1'b0;
      color_mode     <= MODE_PINK;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RANGE_MIN:      range_min      <= cfg_data;
        REG_RANGE_MAX:      range_max      <= cfg_data;
        REG_ZERO_SYMMETRIC: zero_symmetric <= cfg_data[0];
        REG_COLOR_MODE:     color_mode     <= cfg_data[MODE_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  // Effective bounds. These follow the registers only, which the user, not
  // the block, must hold while words are in flight. They carry one extra bit,
  // as mirroring the most negative upper bound gives a lower bound one past
  // the largest positive value. A mirrored upper bound saturates instead.
  assign mag_min = range_min[VALUE_WIDTH-1] ? (~range_min + 1'b1) : range_min;
  assign mag_max = range_max[VALUE_WIDTH-1] ? (~range_max + 1'b1) : range_max;
  assign mag_sat = (mag_min > POS_LIMIT) ? POS_LIMIT : mag_min;
  assign min_ext = {range_min[VALUE_WIDTH-1], range_min};
  assign max_ext = {range_max[VALUE_WIDTH-1], range_max};

  always_comb begin
    lo_eff = min_ext;
    hi_eff = max_ext;
    if (zero_symmetric) begin
      if (mag_min > mag_max) begin
        hi_eff = {1'b0, mag_sat};
      end else begin
        lo_eff = -max_ext;
      end
    end
  end

  // The whole chain moves together unless the skid word is occupied.
  assign adv           = !skid_full;
  assign samples.ready = adv;

  dcmap_front u_front (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (samples.valid),
    .in_value (samples.sample_value),
    .lo       (lo_eff),
    .hi       (hi_eff),
    .head     (chain[0])
  );

  for (genvar i = 0; i < DIV_CELLS; i++) begin : g_cell
    dcmap_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .adv  (adv),
      .prev (chain[i]),
      .next (chain[i+1])
    );
  end

  dcmap_shade u_shade (
    .clk        (clk),
    .rst        (rst),
    .tail       (chain[DIV_CELLS]),
    .color_mode (color_mode),
    .colors     (colors),
    .skid_full  (skid_full)
  );

  // Views of the chain's end and the output handshake for the checks below.
  assign tail          = chain[DIV_CELLS];
  assign tail_in_range = tail.valid && !tail.flags.below && !tail.flags.above;
  assign out_refused   = colors.valid && !colors.ready;
  assign green_ok      = colors.green <= colors.red;

  // The skid word is only ever filled behind a held output word.
  `DCMAP_ASSERT_IMPLY(a_skid_behind_out, clk, rst, skid_full, colors.valid, "lone skid word")

  // Filling the skid word needs an output word that was refused.
  `DCMAP_ASSERT_IMPLY(a_skid_fill, clk, rst, $rose(skid_full), $past(out_refused), "early skid")

  // An in-range fraction never exceeds one.
  `DCMAP_ASSERT_IMPLY(a_quot_range, clk, rst, tail_in_range, tail.quot <= QUOT_ONE, "big quotient")

  // Green never exceeds red in any of the three mid-colour modes.
  `DCMAP_ASSERT_IMPLY(a_green_le_red, clk, rst, colors.valid, green_ok, "green above red")

  // A word at the end of the chain waits there while the skid word is held.
  `DCMAP_ASSERT_NEXT(a_tail_holds, clk, rst, tail.valid && skid_full, tail.valid, "word lost")

endmodule

`default_nettype wire

@@ hw/rtl/dcmap_front.sv @@
`default_nettype none

module dcmap_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              in_valid,
  input  dcmap_pkg::value_t in_value,
  input  dcmap_pkg::bound_t lo,
  input  dcmap_pkg::bound_t hi,
  output dcmap_pkg::cell_t  head
);
  import dcmap_pkg::*;

  logic                   a_valid;
  value_t                 a_value;
  bound_t                 a_ext;
  bound_t                 span_ext;
  bound_t                 offset_ext;
  logic                   a_below;
  logic                   a_above;

  logic                   b_valid;
  logic                   b_below;
  logic                   b_above;
  logic [VALUE_WIDTH-1:0] b_span;
  logic [VALUE_WIDTH-1:0] b_offset;

  logic [REM_WIDTH-1:0]   two_offset;
  logic [REM_WIDTH-1:0]   span_wide;
  logic [REM_WIDTH-1:0]   fold;
  logic                   lower;
  logic                   span_zero;
  cell_t                  head_next;

  // First stage: range tests and the two distances from the lower bound.
  // Inside the range both distances fit the unsigned value width.
  assign a_ext      = {a_value[VALUE_WIDTH-1], a_value};
  assign a_below    = a_ext < lo;
  assign a_above    = a_ext > hi;
  assign span_ext   = hi - lo;
  assign offset_ext = a_ext - lo;

  // Second stage: pick the half and fold the upper half onto [0, span].
  assign two_offset = {b_offset, 1'b0};
  assign span_wide  = {1'b0, b_span};
  assign lower      = two_offset < span_wide;
  assign fold       = lower ? two_offset : two_offset - span_wide;
  assign span_zero  = (b_span == '0);

  always_comb begin
    head_next.valid       = b_valid;
    head_next.flags.below = b_below;
    head_next.flags.above = b_above;
    head_next.flags.lower = lower;
    // An empty range divides zero by one, which yields a zero fraction.
    head_next.rem         = span_zero ? '0 : fold;
    head_next.divisor     = span_zero ? VALUE_WIDTH'(1) : b_span;
    head_next.quot        = '0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_value  <= in_value;
      b_below  <= a_below;
      b_above  <= a_above;
      b_span   <= span_ext[VALUE_WIDTH-1:0];
      b_offset <= offset_ext[VALUE_WIDTH-1:0];
    end
    if (rst) begin
      a_valid    <= 1'b0;
      b_valid    <= 1'b0;
      head.valid <= 1'b0;
    end else if (adv) begin
      a_valid <= in_valid;
      b_valid <= a_valid;
      head    <= head_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/dcmap_cell.sv @@
`default_nettype none

module dcmap_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  dcmap_pkg::cell_t prev,
  output dcmap_pkg::cell_t next
);
  import dcmap_pkg::*;

  logic                 fits;
  logic [REM_WIDTH-1:0] rem_left;
  cell_t                next_d;

  // One restoring step: subtract the divisor when it fits, emit one
  // quotient bit and double the remainder for the following cell.
  assign fits     = prev.rem >= {1'b0, prev.divisor};
  assign rem_left = fits ? prev.rem - {1'b0, prev.divisor} : prev.rem;

  always_comb begin
    next_d         = prev;
    next_d.rem     = {rem_left[REM_WIDTH-2:0], 1'b0};
    next_d.quot    = {prev.quot[QUOT_WIDTH-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next.valid <= 1'b0;
    end else if (adv) begin
      next <= next_d;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/dcmap_shade.sv @@
`default_nettype none

module dcmap_shade (
  input  logic              clk,
  input  logic              rst,
  input  dcmap_pkg::cell_t  tail,
  input  dcmap_pkg::mode_t  color_mode,
  dcmap_color_if.source     colors,
  output logic              skid_full
);
  import dcmap_pkg::*;

  localparam int PROD_WIDTH = QUOT_WIDTH + COLOR_WIDTH;
  localparam logic [PROD_WIDTH-1:0] ROUND_HALF = PROD_WIDTH'(1) << (FRAC_BITS - 1);

  logic [PROD_WIDTH-1:0]  scaled;
  logic [COLOR_WIDTH:0]   level_raw;
  color_t                 level;
  rgb_t                   shade;
  logic                   out_valid;
  logic                   out_free;
  rgb_t                   out_word;
  rgb_t                   skid_word;

  // Fraction times full scale, rounded to the nearest level.
  assign scaled    = PROD_WIDTH'(tail.quot) * PROD_WIDTH'(COLOR_FULL) + ROUND_HALF;
  assign level_raw = scaled[PROD_WIDTH-1:FRAC_BITS];
  assign level     = (level_raw > {1'b0, COLOR_FULL}) ? COLOR_FULL
                                                      : level_raw[COLOR_WIDTH-1:0];

  always_comb begin
    shade = '0;
    if (tail.flags.below) begin
      shade.blue = COLOR_FULL;
    end else if (tail.flags.above) begin
      shade.red = COLOR_FULL;
    end else if (tail.flags.lower) begin
      shade.red = level;
      case (color_mode)
        MODE_WHITE: begin
          shade.green = level;
          shade.blue  = COLOR_FULL;
        end
        MODE_YELLOW: begin
          shade.green = level;
          shade.blue  = COLOR_FULL - level;
        end
        default: begin
          shade.blue = COLOR_FULL;
        end
      endcase
    end else begin
      shade.red = COLOR_FULL;
      case (color_mode)
        MODE_WHITE: begin
          shade.green = COLOR_FULL - level;
          shade.blue  = COLOR_FULL - level;
        end
        MODE_YELLOW: begin
          shade.green = COLOR_FULL - level;
        end
        default: begin
          shade.blue = COLOR_FULL - level;
        end
      endcase
    end
  end

  // Output register with one skid word behind it. The chain only stops
  // once the skid word is filled, so the chain sees a registered stall.
  assign out_free = !out_valid || colors.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (out_free) begin
      if (skid_full) begin
        out_valid <= 1'b1;
        out_word  <= skid_word;
        skid_full <= 1'b0;
      end else begin
        out_valid <= tail.valid;
        out_word  <= shade;
      end
    end else if (!skid_full && tail.valid) begin
      skid_full <= 1'b1;
      skid_word <= shade;
    end
  end

  assign colors.valid = out_valid;
  assign colors.red   = out_word.red;
  assign colors.green = out_word.green;
  assign colors.blue  = out_word.blue;

endmodule

`default_nettype wire
